// File: rtl/uart_pkg.sv
// Shared types and constants for the 8N1 UART transceiver.
// No dependencies; compiled first.
package uart_pkg;

  localparam int DATA_BITS_DEF = 8;
  localparam int PERIOD_W      = 16;
  localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST = 16'd104;

  // APB register map: one 32-bit register per word
  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;
  localparam int REG_IDX_W  = ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_BIT_PERIOD = 1'b0;

  typedef struct packed {
    logic       rx_line;
    logic       send_request;
    logic [7:0] send_byte;
    logic       clear_ready;
  } tick_t;

  typedef struct packed {
    logic tx_line;
    logic tx_busy;
  } tx_stat_t;

  typedef struct packed {
    logic       rx_ready;
    logic [7:0] rx_byte;
  } rx_stat_t;

endpackage

// File: rtl/uart_tick_if.sv
// Input channel of the UART transceiver: one prescaled tick per transfer.
// Valid/ready handshake; no package dependency.
interface uart_tick_if;
  logic       valid;
  logic       ready;
  logic       rx_line;
  logic       send_request;
  logic [7:0] send_byte;
  logic       clear_ready;

  modport source (output valid, output rx_line, output send_request, output send_byte,
                  output clear_ready, input ready);
  modport sink   (input valid, input rx_line, input send_request, input send_byte,
                  input clear_ready, output ready);
endinterface

// File: rtl/uart_status_if.sv
// Result channel of the UART transceiver: line and flag status per tick.
// Valid/ready handshake; no package dependency.
interface uart_status_if;
  logic       valid;
  logic       ready;
  logic       tx_line;
  logic       tx_busy;
  logic       rx_ready;
  logic [7:0] rx_byte;

  modport source (output valid, output tx_line, output tx_busy, output rx_ready,
                  output rx_byte, input ready);
  modport sink   (input valid, input tx_line, input tx_busy, input rx_ready,
                  input rx_byte, output ready);
endinterface

// File: rtl/uart_tx.sv
// UART transmitter: start bit, DATA_BITS data bits LSB first, stop bit.
// Advances one tick per enable. Depends on uart_pkg.
module uart_tx #(
  parameter int DATA_BITS = uart_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [uart_pkg::PERIOD_W-1:0] bit_period,
  input  logic                          send_request,
  input  logic [7:0]                    send_byte,
  output uart_pkg::tx_stat_t            stat
);
  import uart_pkg::*;

  localparam int FRAME_BITS = DATA_BITS + 2;
  localparam int BLW        = $clog2(FRAME_BITS + 1);

  logic [FRAME_BITS-1:0] tx_shift, tx_shift_next, shift_cur;
  logic [BLW-1:0]        tx_bits_left, tx_bits_left_next, left_cur;
  logic [PERIOD_W-1:0]   tx_tick_count, tx_tick_count_next, count_cur;
  logic [DATA_BITS+7:0]  byte_ext;
  logic [PERIOD_W:0]     count_inc;
  logic                  busy;

  assign byte_ext = {{DATA_BITS{1'b0}}, send_byte};

  always_comb begin
    shift_cur = tx_shift;
    left_cur  = tx_bits_left;
    count_cur = tx_tick_count;
    // a request is taken only between frames
    if (send_request && (tx_bits_left == '0)) begin
      shift_cur = {1'b1, byte_ext[DATA_BITS-1:0], 1'b0};
      left_cur  = BLW'(FRAME_BITS);
      count_cur = '0;
    end
    busy      = (left_cur != '0);
    count_inc = {1'b0, count_cur} + 1'b1;

    tx_shift_next      = shift_cur;
    tx_bits_left_next  = left_cur;
    tx_tick_count_next = count_cur;
    if (busy) begin
      if (count_inc >= {1'b0, bit_period}) begin
        tx_tick_count_next = '0;
        tx_shift_next      = {1'b1, shift_cur[FRAME_BITS-1:1]};
        tx_bits_left_next  = left_cur - 1'b1;
      end else begin
        tx_tick_count_next = count_inc[PERIOD_W-1:0];
      end
    end

    stat.tx_busy = busy;
    stat.tx_line = busy ? shift_cur[0] : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tx_shift      <= '1;
      tx_bits_left  <= '0;
      tx_tick_count <= '0;
    end else if (adv) begin
      tx_shift      <= tx_shift_next;
      tx_bits_left  <= tx_bits_left_next;
      tx_tick_count <= tx_tick_count_next;
    end
  end

endmodule

// File: rtl/uart_rx.sv
// UART receiver: detects a low start level, samples each bit at mid-bit,
// latches the byte at the stop bit. Depends on uart_pkg.
module uart_rx #(
  parameter int DATA_BITS = uart_pkg::DATA_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          adv,
  input  logic [uart_pkg::PERIOD_W-1:0] bit_period,
  input  logic                          rx_line,
  input  logic                          clear_ready,
  output uart_pkg::rx_stat_t            stat
);
  import uart_pkg::*;

  localparam int IW = $clog2(DATA_BITS + 2);

  logic                rx_active, rx_active_next;
  logic [IW-1:0]       rx_bit_index, rx_bit_index_next;
  logic [PERIOD_W-1:0] rx_tick_count, rx_tick_count_next, limit;
  logic [7:0]          rx_shift, rx_shift_next;
  logic [7:0]          rx_hold, rx_hold_next;
  logic                rx_flag, rx_flag_next;
  logic                latch;

  always_comb begin
    rx_active_next     = rx_active;
    rx_bit_index_next  = rx_bit_index;
    rx_tick_count_next = rx_tick_count;
    rx_shift_next      = rx_shift;
    latch              = 1'b0;
    // half a period to reach mid-start, then a full period per bit
    limit = (rx_bit_index == '0) ? (bit_period >> 1) : bit_period;

    if (rx_active) begin
      rx_tick_count_next = rx_tick_count + 1'b1;
      if (rx_tick_count_next >= limit) begin
        rx_tick_count_next = '0;
        if (rx_bit_index == '0) begin
          rx_bit_index_next = IW'(1);
        end else if (rx_bit_index <= IW'(DATA_BITS)) begin
          // a ninth data bit has no place in the byte
          for (int j = 0; j < 8; j++) begin
            if (rx_line && (int'(rx_bit_index) == j + 1)) rx_shift_next[j] = 1'b1;
          end
          rx_bit_index_next = rx_bit_index + 1'b1;
        end else begin
          latch             = 1'b1;
          rx_active_next    = 1'b0;
          rx_bit_index_next = '0;
        end
      end
    end else if (!rx_line) begin
      rx_active_next     = 1'b1;
      rx_bit_index_next  = '0;
      rx_tick_count_next = '0;
      rx_shift_next      = '0;
    end

    rx_hold_next = rx_hold;
    rx_flag_next = rx_flag;
    if (clear_ready) begin
      rx_hold_next = '0;
      rx_flag_next = 1'b0;
    end
    if (latch) begin
      rx_hold_next = rx_shift_next;
      rx_flag_next = 1'b1;
    end

    stat.rx_ready = rx_flag_next;
    stat.rx_byte  = rx_hold_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rx_active     <= 1'b0;
      rx_bit_index  <= '0;
      rx_tick_count <= '0;
      rx_shift      <= '0;
      rx_hold       <= '0;
      rx_flag       <= 1'b0;
    end else if (adv) begin
      rx_active     <= rx_active_next;
      rx_bit_index  <= rx_bit_index_next;
      rx_tick_count <= rx_tick_count_next;
      rx_shift      <= rx_shift_next;
      rx_hold       <= rx_hold_next;
      rx_flag       <= rx_flag_next;
    end
  end

endmodule

// File: rtl/uart_8n1_transceiver.sv
// Tick-driven UART, 8N1 by default. Each transfer on the tick channel is one
// prescaled tick and yields exactly one status transfer, in order. One tick
// is taken every clock cycle at full rate; a tick's status passes the input
// register, then the result register, before it is presented, and a stalled
// status channel holds the tick channel back. The rate is set by the single
// registered update of the transmit and receive counters per tick.
// bit_period (reset 104) is written over APB at byte address 0; the user must
// write it only while idle, which the block itself does not enforce.
module uart_8n1_transceiver #(
  parameter int DATA_BITS = uart_pkg::DATA_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  uart_tick_if.sink                       tick,
  uart_status_if.source                   status,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [uart_pkg::ADDR_W-1:0]     paddr,
  input  logic [uart_pkg::APB_DATA_W-1:0] pwdata,
  output logic [uart_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import uart_pkg::*;

  logic [PERIOD_W-1:0] bit_period;
  logic                cfg_write;

  tick_t    s1_item;
  logic     s1_valid;
  logic     out_valid;
  logic     out_load;
  logic     adv;
  tx_stat_t tx_stat, tx_out;
  rx_stat_t rx_stat, rx_out;

  // configuration
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      bit_period <= BIT_PERIOD_RST;
    end else if (cfg_write && (paddr[ADDR_W-1:2] == REG_BIT_PERIOD)) begin
      bit_period <= pwdata[PERIOD_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_BIT_PERIOD) prdata = APB_DATA_W'(bit_period);
  end

  // input register -> state update -> result register
  assign out_load   = !out_valid || status.ready;
  assign adv        = s1_valid && out_load;
  assign tick.ready = !s1_valid || out_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick.ready) begin
      s1_valid <= tick.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_item <= '{rx_line: tick.rx_line, send_request: tick.send_request,
                   send_byte: tick.send_byte, clear_ready: tick.clear_ready};
    end
  end

  uart_tx #(.DATA_BITS(DATA_BITS)) u_tx (
    .clk          (clk),
    .rst          (rst),
    .adv          (adv),
    .bit_period   (bit_period),
    .send_request (s1_item.send_request),
    .send_byte    (s1_item.send_byte),
    .stat         (tx_stat)
  );

  uart_rx #(.DATA_BITS(DATA_BITS)) u_rx (
    .clk         (clk),
    .rst         (rst),
    .adv         (adv),
    .bit_period  (bit_period),
    .rx_line     (s1_item.rx_line),
    .clear_ready (s1_item.clear_ready),
    .stat        (rx_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tx_out <= tx_stat;
      rx_out <= rx_stat;
    end
  end

  assign status.valid    = out_valid;
  assign status.tx_line  = tx_out.tx_line;
  assign status.tx_busy  = tx_out.tx_busy;
  assign status.rx_ready = rx_out.rx_ready;
  assign status.rx_byte  = rx_out.rx_byte;

  // a tick held in the input register is never dropped
  a_s1_kept: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !adv |=> s1_valid)
    else $error("input register lost a tick");

  // every accepted tick reaches the input register
  a_s1_fill: assert property (@(posedge clk) disable iff (rst)
    tick.valid && tick.ready |=> s1_valid)
    else $error("accepted tick not registered");

  // an idle transmitter drives the line high
  a_tx_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !tx_out.tx_busy |-> tx_out.tx_line)
    else $error("tx line low while idle");

  // a stalled status transfer keeps its contents
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status.ready |=> out_valid && $stable(tx_out) && $stable(rx_out))
    else $error("stalled status changed");

endmodule

// File: bench/tb_uart_8n1_transceiver.sv
// Self-checking bench for uart_8n1_transceiver: ticks are driven on the tick
// channel, each status transfer is checked against a tick-accurate UART model.
// Depends on uart_pkg, uart_tick_if and uart_status_if from the RTL.
module tb_uart_8n1_transceiver;
  import uart_pkg::*;

  localparam int DBITS     = DATA_BITS_DEF;
  localparam int LIMIT     = 500000;
  localparam int RAND_TICKS = 700;
  localparam logic [ADDR_W-1:0] BIT_PERIOD_ADDR = {REG_BIT_PERIOD, 2'b00};

  typedef struct packed {
    logic       tx_line;
    logic       tx_busy;
    logic       rx_ready;
    logic [7:0] rx_byte;
  } line_status_t;

  logic clk;
  logic rst;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic pready;

  uart_tick_if   tick_ch ();
  uart_status_if status_ch ();

  uart_8n1_transceiver uut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_ch),
    .status  (status_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  line_status_t expected_status[$];
  bit           rx_levels[$];
  int           error_count = 0;
  int           cycle_count = 0;
  int           random_ticks = 0;
  bit           no_gaps = 0;

  // UART model state
  logic [15:0]      period_m;
  logic [DBITS+1:0] tx_sr;
  logic [3:0]       tx_left;
  logic [15:0]      tx_cnt;
  logic             rx_on;
  logic [3:0]       rx_idx;
  logic [15:0]      rx_cnt;
  logic [7:0]       rx_sr;
  logic [7:0]       rx_hold_m;
  logic             rx_flag_m;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  task automatic report_mismatch(input string what);
    $display("cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  task automatic uart_model_reset();
    period_m  = BIT_PERIOD_RST;
    tx_sr     = '1;
    tx_left   = '0;
    tx_cnt    = '0;
    rx_on     = 1'b0;
    rx_idx    = '0;
    rx_cnt    = '0;
    rx_sr     = '0;
    rx_hold_m = '0;
    rx_flag_m = 1'b0;
  endtask

  // One tick of the UART: transmitter, then receiver, then clear and latch.
  task automatic predict_line_status(input tick_t t);
    line_status_t e;
    logic         latch;
    logic [15:0]  lim;
    logic [16:0]  nxt;
    latch = 1'b0;
    if (t.send_request && tx_left == 0) begin
      tx_sr = '0;
      tx_sr[DBITS+1] = 1'b1;
      tx_sr[8:1] = t.send_byte;
      tx_left = 4'(DBITS + 2);
      tx_cnt = '0;
    end
    e.tx_busy = (tx_left != 0);
    e.tx_line = e.tx_busy ? tx_sr[0] : 1'b1;
    if (e.tx_busy) begin
      nxt = {1'b0, tx_cnt} + 17'd1;
      if (nxt >= {1'b0, period_m}) begin
        tx_cnt = '0;
        tx_sr = {1'b1, tx_sr[DBITS+1:1]};
        tx_left--;
      end else begin
        tx_cnt = nxt[15:0];
      end
    end

    if (rx_on) begin
      lim = (rx_idx == 0) ? (period_m >> 1) : period_m;
      rx_cnt = rx_cnt + 16'd1;
      if (rx_cnt >= lim) begin
        rx_cnt = '0;
        if (rx_idx == 0) begin
          rx_idx = 4'd1;
        end else if (rx_idx <= DBITS) begin
          // a ninth data bit is sampled for timing but dropped
          if (t.rx_line && rx_idx <= 8) rx_sr[rx_idx-1] = 1'b1;
          rx_idx++;
        end else begin
          latch = 1'b1;
          rx_on = 1'b0;
          rx_idx = '0;
        end
      end
    end else if (!t.rx_line) begin
      rx_on = 1'b1;
      rx_idx = '0;
      rx_cnt = '0;
      rx_sr = '0;
    end

    if (t.clear_ready) begin
      rx_flag_m = 1'b0;
      rx_hold_m = '0;
    end
    if (latch) begin
      rx_hold_m = rx_sr;
      rx_flag_m = 1'b1;
    end
    e.rx_ready = rx_flag_m;
    e.rx_byte  = rx_hold_m;
    expected_status.push_back(e);
  endtask

  // Entered and left at a falling edge; valid stays high into a back-to-back tick.
  task automatic send_tick(input tick_t t);
    int g;
    tick_ch.valid        = 1'b1;
    tick_ch.rx_line      = t.rx_line;
    tick_ch.send_request = t.send_request;
    tick_ch.send_byte    = t.send_byte;
    tick_ch.clear_ready  = t.clear_ready;
    @(posedge clk);
    while (!tick_ch.ready) @(posedge clk);
    predict_line_status(t);
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      tick_ch.valid = 1'b0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    tick_ch.valid = 1'b0;
    while (expected_status.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_bit_period(input logic [15:0] value);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = BIT_PERIOD_ADDR;
    pwdata  = {16'd0, value};
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    period_m = value;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  task automatic queue_rx_frame(input logic [7:0] data, input int p, input bit stop_lvl);
    int hold;
    hold = (p < 2) ? 1 : p;
    repeat (hold) rx_levels.push_back(1'b0);
    for (int i = 0; i < DBITS; i++) begin
      repeat (hold) rx_levels.push_back((i < 8) ? data[i] : 1'b1);
    end
    repeat (hold) rx_levels.push_back(stop_lvl);
  endtask

  function automatic bit next_rx_level();
    if (rx_levels.size() == 0) return 1'b1;
    return rx_levels.pop_front();
  endfunction

  task automatic run_directed(input int n, input bit req, input logic [7:0] b,
                              input int clr_from);
    tick_t t;
    for (int i = 0; i < n; i++) begin
      t.rx_line      = next_rx_level();
      t.send_request = req;
      t.send_byte    = b;
      t.clear_ready  = (clr_from >= 0 && i >= clr_from);
      send_tick(t);
    end
  endtask

  // Reset value of the period, idle line levels after reset, then a frame starts.
  task automatic test_reset_state();
    run_directed(3, 1'b0, 8'h00, -1);
    run_directed(1, 1'b1, 8'h00, -1);
  endtask

  // One tick per bit; second received byte overwrites the unread first.
  task automatic test_short_period_overwrite();
    wait_idle();
    write_bit_period(16'd1);
    queue_rx_frame(8'hFF, 1, 1'b1);
    queue_rx_frame(8'h00, 1, 1'b1);
    run_directed(1, 1'b1, 8'hFF, -1);
    run_directed(23, 1'b1, 8'h00, -1);
  endtask

  // Clear held over the end of a frame, so it meets the latch.
  task automatic test_clear_with_latch();
    queue_rx_frame(8'hA5, 1, 1'b1);
    run_directed(13, 1'b0, 8'h00, 8);
  endtask

  // Zero period; a one-tick low glitch still starts a frame.
  task automatic test_zero_period_glitch();
    wait_idle();
    write_bit_period(16'd0);
    rx_levels.push_back(1'b0);
    run_directed(12, 1'b1, 8'h55, -1);
  endtask

  // Low stop bit goes unnoticed.
  task automatic test_bad_stop_bit();
    wait_idle();
    write_bit_period(16'd2);
    queue_rx_frame(8'h3C, 2, 1'b0);
    run_directed(24, 1'b0, 8'hAA, 22);
  endtask

  task automatic run_random_phase(input int p, input int n);
    tick_t t;
    int    r;
    int    hold;
    hold = (p < 2) ? 1 : p;
    for (int i = 0; i < n; i++) begin
      if (rx_levels.size() == 0) begin
        r = $urandom_range(0, 99);
        if (p <= 16 && r < 70) begin
          queue_rx_frame(8'($urandom), p, $urandom_range(0, 9) != 0);
          repeat ($urandom_range(0, 2 * hold)) rx_levels.push_back(1'b1);
        end else if (r < 88) begin
          repeat ($urandom_range(1, 4)) rx_levels.push_back(1'($urandom));
        end else begin
          repeat ($urandom_range(1, 6)) rx_levels.push_back(1'b1);
        end
      end
      t.rx_line      = next_rx_level();
      t.send_request = ($urandom_range(0, 3) == 0);
      t.send_byte    = 8'($urandom);
      t.clear_ready  = ($urandom_range(0, 15) == 0);
      send_tick(t);
      random_ticks++;
    end
  endtask

  // Each phase picks a new period; a large one is left mid-frame on purpose.
  task automatic test_random_phases();
    int phase;
    int r;
    int p;
    phase = 0;
    while (random_ticks < RAND_TICKS) begin
      r = $urandom_range(0, 9);
      if (phase == 1 || r == 9) p = 65535;
      else if (r < 6) p = $urandom_range(2, 8);
      else if (r < 7) p = $urandom_range(0, 1);
      else p = $urandom_range(9, 16);
      wait_idle();
      no_gaps = ($urandom_range(0, 4) == 0);
      write_bit_period(16'(p));
      run_random_phase(p, (p > 16) ? 40 : $urandom_range(60, 160));
      phase++;
    end
    no_gaps = 1'b0;
  endtask

  // Result side: random back-pressure.
  initial begin
    int stall;
    stall = 0;
    status_ch.ready = 1'b1;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        status_ch.ready = 1'b0;
        stall--;
      end else begin
        status_ch.ready = 1'b1;
        stall = gap_len();
      end
    end
  end

  always @(posedge clk) begin
    line_status_t e;
    if (!rst && status_ch.valid === 1'b1 && status_ch.ready) begin
      if (expected_status.size() == 0) begin
        report_mismatch("status transfer with nothing expected");
      end else begin
        e = expected_status.pop_front();
        if (status_ch.tx_line !== e.tx_line)
          report_mismatch($sformatf("tx_line expected %0b got %0b", e.tx_line,
                                    status_ch.tx_line));
        if (status_ch.tx_busy !== e.tx_busy)
          report_mismatch($sformatf("tx_busy expected %0b got %0b", e.tx_busy,
                                    status_ch.tx_busy));
        if (status_ch.rx_ready !== e.rx_ready)
          report_mismatch($sformatf("rx_ready expected %0b got %0b", e.rx_ready,
                                    status_ch.rx_ready));
        if (status_ch.rx_byte !== e.rx_byte)
          report_mismatch($sformatf("rx_byte expected %02h got %02h", e.rx_byte,
                                    status_ch.rx_byte));
      end
    end
  end

  initial begin
    rst                  = 1'b1;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    tick_ch.valid        = 1'b0;
    tick_ch.rx_line      = 1'b1;
    tick_ch.send_request = 1'b0;
    tick_ch.send_byte    = '0;
    tick_ch.clear_ready  = 1'b0;
    uart_model_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_short_period_overwrite();
    test_clear_with_latch();
    test_zero_period_glitch();
    test_bad_stop_bit();
    test_random_phases();

    wait_idle();
    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/uart_pkg.sv
rtl/uart_tick_if.sv
rtl/uart_status_if.sv
rtl/uart_tx.sv
rtl/uart_rx.sv
rtl/uart_8n1_transceiver.sv
bench/tb_uart_8n1_transceiver.sv
